// ===== hdl/ptq_pkg.sv =====
// Shared types, codes and default sizes for the pausable timer event queue.
package ptq_pkg;

    // Default sizes
    localparam int DEF_SLOTS     = 16;
    localparam int DEF_MAX_FIRES = 32;
    localparam int DEF_TIME_BITS = 48;

    // Fixed field widths
    localparam int OP_W   = 3;
    localparam int SLOT_W = 4;
    localparam int DLY_W  = 32;
    localparam int PER_W  = 33;
    localparam int STEP_W = 16;
    localparam int KIND_W = 2;
    localparam int REM_W  = 48;

    // Command codes
    typedef enum logic [OP_W-1:0] {
        OP_ARM     = 3'd0,
        OP_ADVANCE = 3'd1,
        OP_UPDATE  = 3'd2,
        OP_PAUSE   = 3'd3,
        OP_START   = 3'd4,
        OP_QUERY   = 3'd5
    } opcode_t;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_DONE  = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_REPLY = 2'd2
    } kind_t;

    // Shared adder operation
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_QRD,
        ST_QCALC,
        ST_SCAN,
        ST_DECIDE,
        ST_FIRE,
        ST_FINAL
    } state_t;

endpackage

// ===== hdl/ptq_alu.sv =====
// Shared time adder/subtractor used by the arm, advance, query and update commands of the timer queue.
module ptq_alu #(
    parameter int TIME_BITS = ptq_pkg::DEF_TIME_BITS
) (
    input  ptq_pkg::alu_op_t       op,
    input  logic [TIME_BITS-1:0]   a,
    input  logic [TIME_BITS-1:0]   b,
    output logic [TIME_BITS-1:0]   result,
    output logic                   carry
);

    logic [TIME_BITS-1:0] b_eff;
    logic [TIME_BITS:0]   full;

    // Subtract as a + ~b + 1; carry set means a >= b
    always_comb
    begin
        b_eff  = (op == ptq_pkg::ALU_SUB) ? ~b : b;
        full   = {1'b0, a} + {1'b0, b_eff} + {{TIME_BITS{1'b0}}, (op == ptq_pkg::ALU_SUB)};
        result = full[TIME_BITS-1:0];
        carry  = full[TIME_BITS];
    end

endmodule

// ===== hdl/pausable_timer_event_queue.sv =====
// Top level: slot table, scheduler clock and command sequencer of the timer queue.
// Arm, advance, pause, start and unknown codes go through the EXEC state to the output
// register; query goes through QRD and QCALC. Update scans the slot memory one entry per
// cycle and scans it again after each firing. One command is in work at a time; the next
// transfer is taken on return to idle. Reset (rst_n low, asynchronous) disarms all slots,
// zeroes the clock and sets running; the slot memory is not cleared, and its contents are
// only used for armed slots.
module pausable_timer_event_queue #(
    parameter int SLOTS     = ptq_pkg::DEF_SLOTS,
    parameter int MAX_FIRES = ptq_pkg::DEF_MAX_FIRES,
    parameter int TIME_BITS = ptq_pkg::DEF_TIME_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ptq_pkg::OP_W-1:0]      opcode,
    input  logic [ptq_pkg::SLOT_W-1:0]    slot,
    input  logic [ptq_pkg::DLY_W-1:0]     delay,
    input  logic signed [ptq_pkg::PER_W-1:0] period,
    input  logic                          repeat_req,
    input  logic [ptq_pkg::STEP_W-1:0]    time_step,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ptq_pkg::KIND_W-1:0]    kind,
    output logic [ptq_pkg::SLOT_W-1:0]    fired_slot,
    output logic [ptq_pkg::REM_W-1:0]     remaining,
    output logic                          last
);

    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(MAX_FIRES + 1);
    localparam int PW    = ptq_pkg::PER_W;
    localparam int ENT_W = TIME_BITS + PW + 1;
    localparam int EXT_W = (TIME_BITS > ptq_pkg::REM_W) ? TIME_BITS : ptq_pkg::REM_W;
    localparam logic [SW:0]       SLOTS_C   = (SW + 1)'(SLOTS);
    localparam logic [CW-1:0]     LAST_FIRE = CW'(MAX_FIRES - 1);
    localparam logic [EXT_W-1:0]  REM_MAX_X = EXT_W'({ptq_pkg::REM_W{1'b1}});

    // Slot memory: {deadline, interval, repeat}
    logic [ENT_W-1:0] slot_mem [SLOTS];
    logic [ENT_W-1:0] rd_data_reg;
    logic [SW-1:0]    rd_addr;
    logic             wr_en;
    logic [SW-1:0]    wr_addr;
    logic [ENT_W-1:0] wr_data;

    // Control state
    ptq_pkg::state_t      state_reg, state_next;
    logic [SLOTS-1:0]     armed_reg, armed_next;
    logic [TIME_BITS-1:0] clock_reg, clock_next;
    logic                 running_reg, running_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic                 best_found_reg, best_found_next;
    logic                 cmp_vld_reg, cmp_vld_next;

    // Command and scan payload
    ptq_pkg::opcode_t     op_reg, op_next;
    logic [ptq_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [ptq_pkg::DLY_W-1:0]  delay_reg, delay_next;
    logic [PW-1:0]        period_reg, period_next;
    logic                 rep_reg, rep_next;
    logic [ptq_pkg::STEP_W-1:0] step_reg, step_next;
    logic [SW:0]          scan_cnt_reg, scan_cnt_next;
    logic [SW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic [SW-1:0]        best_idx_reg, best_idx_next;
    logic [TIME_BITS-1:0] best_dl_reg, best_dl_next;
    logic [PW-1:0]        best_iv_reg, best_iv_next;
    logic                 best_rep_reg, best_rep_next;
    logic [SW-1:0]        pend_slot_reg, pend_slot_next;
    logic [CW-1:0]        fire_cnt_reg, fire_cnt_next;

    // Output register
    logic [ptq_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [ptq_pkg::SLOT_W-1:0] oslot_reg, oslot_next;
    logic [ptq_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic                       last_reg, last_next;

    // Shared adder
    ptq_pkg::alu_op_t     alu_op;
    logic [TIME_BITS-1:0] alu_a, alu_b, alu_y;
    logic                 alu_c;

    ptq_alu #(
        .TIME_BITS (TIME_BITS)
    ) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_y),
        .carry  (alu_c)
    );

    // Read-data fields
    logic [TIME_BITS-1:0] rd_dl;
    logic [PW-1:0]        rd_iv;
    logic                 rd_rep;
    logic                 out_free;
    logic                 emit;
    logic                 slot_ok;
    logic [SW-1:0]        slot_idx;
    logic                 issue;
    logic                 due;
    logic [EXT_W-1:0]     diff_ext;

    assign rd_dl  = rd_data_reg[ENT_W-1:PW+1];
    assign rd_iv  = rd_data_reg[PW:1];
    assign rd_rep = rd_data_reg[0];

    assign out_free = !out_valid_reg || !out_stall;
    assign slot_ok  = (32'(slot_reg) < SLOTS);
    assign slot_idx = SW'(slot_reg);
    assign in_stall = (state_reg != ptq_pkg::ST_IDLE);

    // Sequencer: next state, datapath control and results
    always_comb
    begin
        state_next      = state_reg;
        armed_next      = armed_reg;
        clock_next      = clock_reg;
        running_next    = running_reg;
        pend_vld_next   = pend_vld_reg;
        best_found_next = best_found_reg;
        cmp_vld_next    = 1'b0;
        op_next         = op_reg;
        slot_next       = slot_reg;
        delay_next      = delay_reg;
        period_next     = period_reg;
        rep_next        = rep_reg;
        step_next       = step_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_idx_next    = cmp_idx_reg;
        best_idx_next   = best_idx_reg;
        best_dl_next    = best_dl_reg;
        best_iv_next    = best_iv_reg;
        best_rep_next   = best_rep_reg;
        pend_slot_next  = pend_slot_reg;
        fire_cnt_next   = fire_cnt_reg;

        emit      = 1'b0;
        kind_next = kind_reg;
        oslot_next = oslot_reg;
        rem_next  = rem_reg;
        last_next = last_reg;

        rd_addr = slot_idx;
        wr_en   = 1'b0;
        wr_addr = slot_idx;
        wr_data = {alu_y, period_reg, rep_reg};

        alu_op = ptq_pkg::ALU_ADD;
        alu_a  = clock_reg;
        alu_b  = TIME_BITS'(delay_reg);

        issue    = 1'b0;
        due      = 1'b0;
        diff_ext = '0;

        unique case (state_reg)
            ptq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = ptq_pkg::opcode_t'(opcode);
                    slot_next       = slot;
                    delay_next      = delay;
                    period_next     = period;
                    rep_next        = repeat_req;
                    step_next       = time_step;
                    scan_cnt_next   = '0;
                    best_found_next = 1'b0;
                    pend_vld_next   = 1'b0;
                    fire_cnt_next   = '0;
                    if (ptq_pkg::opcode_t'(opcode) == ptq_pkg::OP_UPDATE)
                        state_next = ptq_pkg::ST_SCAN;
                    else if (ptq_pkg::opcode_t'(opcode) == ptq_pkg::OP_QUERY)
                        state_next = ptq_pkg::ST_QRD;
                    else
                        state_next = ptq_pkg::ST_EXEC;
                end
            end

            // Single-result commands, applied on the cycle the done result goes out
            ptq_pkg::ST_EXEC:
            begin
                if (op_reg == ptq_pkg::OP_ADVANCE)
                    alu_b = TIME_BITS'(step_reg);
                if (out_free)
                begin
                    case (op_reg)
                        ptq_pkg::OP_ARM:
                        begin
                            if (slot_ok)
                            begin
                                wr_en                = 1'b1;
                                armed_next[slot_idx] = 1'b1;
                            end
                        end
                        ptq_pkg::OP_ADVANCE:
                        begin
                            if (running_reg)
                                clock_next = alu_y;
                        end
                        ptq_pkg::OP_PAUSE: running_next = 1'b0;
                        ptq_pkg::OP_START: running_next = 1'b1;
                        default: ;
                    endcase
                    emit       = 1'b1;
                    kind_next  = ptq_pkg::KIND_DONE;
                    oslot_next = '0;
                    rem_next   = '0;
                    last_next  = 1'b1;
                    state_next = ptq_pkg::ST_IDLE;
                end
            end

            ptq_pkg::ST_QRD:
            begin
                state_next = ptq_pkg::ST_QCALC;
            end

            // Remaining time: deadline - now, clamped at zero and saturated
            ptq_pkg::ST_QCALC:
            begin
                alu_op = ptq_pkg::ALU_SUB;
                alu_a  = rd_dl;
                alu_b  = clock_reg;
                diff_ext = EXT_W'(alu_y);
                if (out_free)
                begin
                    emit       = 1'b1;
                    kind_next  = ptq_pkg::KIND_REPLY;
                    oslot_next = slot_reg;
                    rem_next   = '0;
                    if (slot_ok && armed_reg[slot_idx] && alu_c && (alu_y != '0))
                    begin
                        if (diff_ext > REM_MAX_X)
                            rem_next = {ptq_pkg::REM_W{1'b1}};
                        else
                            rem_next = diff_ext[ptq_pkg::REM_W-1:0];
                    end
                    last_next  = 1'b1;
                    state_next = ptq_pkg::ST_IDLE;
                end
            end

            // Earliest-deadline search, one slot per cycle
            ptq_pkg::ST_SCAN:
            begin
                issue   = (scan_cnt_reg < SLOTS_C);
                rd_addr = scan_cnt_reg[SW-1:0];
                if (issue)
                begin
                    scan_cnt_next = scan_cnt_reg + (SW + 1)'(1);
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[SW-1:0];
                end
                if (cmp_vld_reg)
                begin
                    due = armed_reg[cmp_idx_reg] && (rd_dl <= clock_reg);
                    if (due && (!best_found_reg || (rd_dl < best_dl_reg)))
                    begin
                        best_found_next = 1'b1;
                        best_idx_next   = cmp_idx_reg;
                        best_dl_next    = rd_dl;
                        best_iv_next    = rd_iv;
                        best_rep_next   = rd_rep;
                    end
                end
                if (!issue && !cmp_vld_reg)
                    state_next = ptq_pkg::ST_DECIDE;
            end

            // Release the previous firing once it is known whether more follow
            ptq_pkg::ST_DECIDE:
            begin
                if (best_found_reg)
                begin
                    if (!pend_vld_reg || out_free)
                    begin
                        if (pend_vld_reg)
                        begin
                            emit       = 1'b1;
                            kind_next  = ptq_pkg::KIND_FIRED;
                            oslot_next = ptq_pkg::SLOT_W'(pend_slot_reg);
                            rem_next   = '0;
                            last_next  = 1'b0;
                        end
                        state_next = ptq_pkg::ST_FIRE;
                    end
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    kind_next  = pend_vld_reg ? ptq_pkg::KIND_FIRED : ptq_pkg::KIND_DONE;
                    oslot_next = pend_vld_reg ? ptq_pkg::SLOT_W'(pend_slot_reg) : '0;
                    rem_next   = '0;
                    last_next  = 1'b1;
                    state_next = ptq_pkg::ST_IDLE;
                end
            end

            // Fire the chosen slot: re-arm or disarm
            ptq_pkg::ST_FIRE:
            begin
                alu_a   = best_dl_reg;
                alu_b   = TIME_BITS'(best_iv_reg[PW-2:0]);
                wr_addr = best_idx_reg;
                wr_data = {alu_y, best_iv_reg, best_rep_reg};
                if (best_rep_reg && !best_iv_reg[PW-1])
                    wr_en = 1'b1;
                else
                    armed_next[best_idx_reg] = 1'b0;
                pend_vld_next   = 1'b1;
                pend_slot_next  = best_idx_reg;
                fire_cnt_next   = fire_cnt_reg + CW'(1);
                scan_cnt_next   = '0;
                best_found_next = 1'b0;
                if (fire_cnt_reg == LAST_FIRE)
                    state_next = ptq_pkg::ST_FINAL;
                else
                    state_next = ptq_pkg::ST_SCAN;
            end

            // Firing limit reached: last result of the update
            ptq_pkg::ST_FINAL:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    kind_next  = ptq_pkg::KIND_FIRED;
                    oslot_next = ptq_pkg::SLOT_W'(pend_slot_reg);
                    rem_next   = '0;
                    last_next  = 1'b1;
                    state_next = ptq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ptq_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = emit ? 1'b1 : (out_valid_reg && out_stall);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ptq_pkg::ST_IDLE;
            armed_reg      <= '0;
            clock_reg      <= '0;
            running_reg    <= 1'b1;
            out_valid_reg  <= 1'b0;
            pend_vld_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            armed_reg      <= armed_next;
            clock_reg      <= clock_next;
            running_reg    <= running_next;
            out_valid_reg  <= out_valid_next;
            pend_vld_reg   <= pend_vld_next;
            best_found_reg <= best_found_next;
            cmp_vld_reg    <= cmp_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        slot_reg      <= slot_next;
        delay_reg     <= delay_next;
        period_reg    <= period_next;
        rep_reg       <= rep_next;
        step_reg      <= step_next;
        scan_cnt_reg  <= scan_cnt_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_idx_reg  <= best_idx_next;
        best_dl_reg   <= best_dl_next;
        best_iv_reg   <= best_iv_next;
        best_rep_reg  <= best_rep_next;
        pend_slot_reg <= pend_slot_next;
        fire_cnt_reg  <= fire_cnt_next;
        kind_reg      <= kind_next;
        oslot_reg     <= oslot_next;
        rem_reg       <= rem_next;
        last_reg      <= last_next;
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_mem[wr_addr] <= wr_data;
        rd_data_reg <= slot_mem[rd_addr];
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign fired_slot = oslot_reg;
    assign remaining  = rem_reg;
    assign last       = last_reg;

endmodule

// ===== sim/ptq_checker.sv =====
// Result checker for the pausable timer event queue: predicts every result and compares it.
`timescale 1ns / 1ps

module ptq_checker #(
    parameter int SLOTS     = ptq_pkg::DEF_SLOTS,
    parameter int MAX_FIRES = ptq_pkg::DEF_MAX_FIRES,
    parameter int TIME_BITS = ptq_pkg::DEF_TIME_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [ptq_pkg::OP_W-1:0]         opcode,
    input  logic [ptq_pkg::SLOT_W-1:0]       slot,
    input  logic [ptq_pkg::DLY_W-1:0]        delay,
    input  logic signed [ptq_pkg::PER_W-1:0] period,
    input  logic                             repeat_req,
    input  logic [ptq_pkg::STEP_W-1:0]       time_step,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [ptq_pkg::KIND_W-1:0]       kind,
    input  logic [ptq_pkg::SLOT_W-1:0]       fired_slot,
    input  logic [ptq_pkg::REM_W-1:0]        remaining,
    input  logic                             last,
    output int                               errors,
    output int                               pending
);

    localparam logic [63:0] REM_CEIL = (64'd1 << ptq_pkg::REM_W) - 64'd1;

    typedef struct packed {
        ptq_pkg::kind_t             kind;
        logic [ptq_pkg::SLOT_W-1:0] slot;
        logic [ptq_pkg::REM_W-1:0]  rem;
        logic                       last;
    } timer_result_t;

    // Shadow copy of the slot table and scheduler clock
    logic [TIME_BITS-1:0]             due_at    [SLOTS];
    logic                             live      [SLOTS];
    logic signed [ptq_pkg::PER_W-1:0] gap_ticks [SLOTS];
    logic                             replay    [SLOTS];
    logic [TIME_BITS-1:0]             now_ticks;
    logic                             ticking;

    timer_result_t awaited[$];

    task automatic report(input string what);
        $display("%0t ns: timer queue mismatch: %s", $time, what);
        errors++;
    endtask

    task automatic push_result(input ptq_pkg::kind_t k,
                               input logic [ptq_pkg::SLOT_W-1:0] s,
                               input logic [ptq_pkg::REM_W-1:0] rem, input logic fin);
        timer_result_t r;
        r.kind = k;
        r.slot = s;
        r.rem  = rem;
        r.last = fin;
        awaited.push_back(r);
    endtask

    // Apply one accepted command to the shadow state and queue its results
    task automatic apply_command(input logic [ptq_pkg::OP_W-1:0] op,
                                 input logic [ptq_pkg::SLOT_W-1:0] s,
                                 input logic [ptq_pkg::DLY_W-1:0] dly,
                                 input logic signed [ptq_pkg::PER_W-1:0] per,
                                 input logic rep,
                                 input logic [ptq_pkg::STEP_W-1:0] step);
        int          pick;
        int          hits[$];
        logic [63:0] left;
        hits = {};
        case (op)
            ptq_pkg::OP_ARM:
            begin
                if (s < SLOTS) begin
                    due_at[s]    = now_ticks + TIME_BITS'(dly);
                    gap_ticks[s] = per;
                    replay[s]    = rep;
                    live[s]      = 1'b1;
                end
                push_result(ptq_pkg::KIND_DONE, '0, '0, 1'b1);
            end
            ptq_pkg::OP_ADVANCE:
            begin
                if (ticking)
                    now_ticks = now_ticks + TIME_BITS'(step);
                push_result(ptq_pkg::KIND_DONE, '0, '0, 1'b1);
            end
            ptq_pkg::OP_UPDATE:
            begin
                // earliest due slot first, lowest index wins a tie
                while (hits.size() < MAX_FIRES) begin
                    pick = -1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (live[i] && due_at[i] <= now_ticks &&
                            (pick < 0 || due_at[i] < due_at[pick]))
                            pick = i;
                    end
                    if (pick < 0)
                        break;
                    if (replay[pick] && gap_ticks[pick] >= 0)
                        due_at[pick] = due_at[pick] + TIME_BITS'(gap_ticks[pick]);
                    else
                        live[pick] = 1'b0;
                    hits.push_back(pick);
                end
                if (hits.size() == 0)
                    push_result(ptq_pkg::KIND_DONE, '0, '0, 1'b1);
                for (int k = 0; k < hits.size(); k++)
                    push_result(ptq_pkg::KIND_FIRED, ptq_pkg::SLOT_W'(hits[k]), '0,
                                k == hits.size() - 1);
            end
            ptq_pkg::OP_PAUSE:
            begin
                ticking = 1'b0;
                push_result(ptq_pkg::KIND_DONE, '0, '0, 1'b1);
            end
            ptq_pkg::OP_START:
            begin
                ticking = 1'b1;
                push_result(ptq_pkg::KIND_DONE, '0, '0, 1'b1);
            end
            ptq_pkg::OP_QUERY:
            begin
                left = '0;
                if (s < SLOTS && live[s] && due_at[s] > now_ticks)
                    left = 64'(due_at[s] - now_ticks);
                if (left > REM_CEIL)
                    left = REM_CEIL;
                push_result(ptq_pkg::KIND_REPLY, s, ptq_pkg::REM_W'(left), 1'b1);
            end
            default:
                push_result(ptq_pkg::KIND_DONE, '0, '0, 1'b1);
        endcase
    endtask

    // Watch both channels at each edge
    always @(posedge clk or negedge rst_n) begin
        timer_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < SLOTS; i++)
                live[i] = 1'b0;
            now_ticks = '0;
            ticking   = 1'b1;
            awaited   = {};
            errors    = 0;
            pending   = 0;
        end
        else begin
            if (in_valid && !in_stall)
                apply_command(opcode, slot, delay, period, repeat_req, time_step);
            if (out_valid && !out_stall) begin
                if (awaited.size() == 0) begin
                    report($sformatf("result with nothing awaited: kind %0d slot %0d",
                                     kind, fired_slot));
                end
                else begin
                    want = awaited.pop_front();
                    if (kind !== want.kind)
                        report($sformatf("kind %0d, awaited %0d", kind, want.kind));
                    if (fired_slot !== want.slot)
                        report($sformatf("fired_slot %0d, awaited %0d",
                                         fired_slot, want.slot));
                    if (remaining !== want.rem)
                        report($sformatf("remaining %0d, awaited %0d",
                                         remaining, want.rem));
                    if (last !== want.last)
                        report($sformatf("last %0b, awaited %0b", last, want.last));
                end
            end
            pending = awaited.size();
        end
    end

endmodule

// ===== sim/tb_pausable_timer_event_queue.sv =====
// Testbench top for the pausable timer event queue: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_pausable_timer_event_queue;

    localparam logic [ptq_pkg::OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [ptq_pkg::OP_W-1:0] OP_RSVD_7 = 3'd7;
    localparam logic signed [ptq_pkg::PER_W-1:0] ONE_SHOT = -33'sd1;
    localparam int QUIET_LIMIT = 5000;
    localparam int RAND_ITEMS  = 105;
    localparam int HOLD_CYCLES = 300;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [ptq_pkg::OP_W-1:0]         opcode;
    logic [ptq_pkg::SLOT_W-1:0]       slot;
    logic [ptq_pkg::DLY_W-1:0]        delay;
    logic signed [ptq_pkg::PER_W-1:0] period;
    logic                             repeat_req;
    logic [ptq_pkg::STEP_W-1:0]       time_step;
    logic                             out_valid;
    logic                             out_stall;
    logic [ptq_pkg::KIND_W-1:0]       kind;
    logic [ptq_pkg::SLOT_W-1:0]       fired_slot;
    logic [ptq_pkg::REM_W-1:0]        remaining;
    logic                             last;

    int    errors;
    int    pending;
    int    rand_sent;

    pausable_timer_event_queue dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .slot       (slot),
        .delay      (delay),
        .period     (period),
        .repeat_req (repeat_req),
        .time_step  (time_step),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .fired_slot (fired_slot),
        .remaining  (remaining),
        .last       (last)
    );

    ptq_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .slot       (slot),
        .delay      (delay),
        .period     (period),
        .repeat_req (repeat_req),
        .time_step  (time_step),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .fired_slot (fired_slot),
        .remaining  (remaining),
        .last       (last),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then long; calm stretches have none
    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: random stalls, plus one long hold-off during the random phase
    initial
    begin
        int  len;
        bit  calm;
        bit  held;
        int  tick;
        out_stall <= 1'b0;
        held = 1'b0;
        calm = 1'b0;
        tick = 0;
        @(posedge clk);
        forever begin
            if (tick % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (!held && rand_sent >= 30) begin
                held = 1'b1;
                len  = HOLD_CYCLES;
            end
            else begin
                len = idle_len(calm);
            end
            if (len > 0) begin
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            tick = tick + len + 1;
        end
    end

    // Watchdog: ends the run after a long stretch with no transfer
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_pausable_timer_event_queue failed");
        $finish;
    end

    bit send_calm;

    // One command transfer followed by an optional gap
    task automatic send_cmd(input logic [ptq_pkg::OP_W-1:0] op,
                            input logic [ptq_pkg::SLOT_W-1:0] s,
                            input logic [ptq_pkg::DLY_W-1:0] dly,
                            input logic signed [ptq_pkg::PER_W-1:0] per,
                            input logic rep, input logic [ptq_pkg::STEP_W-1:0] step);
        int gap;
        opcode     <= op;
        slot       <= s;
        delay      <= dly;
        period     <= per;
        repeat_req <= rep;
        time_step  <= step;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        gap = idle_len(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random command with weighted opcodes
    task automatic send_random;
        int                               r;
        logic [ptq_pkg::SLOT_W-1:0]       s;
        logic [ptq_pkg::DLY_W-1:0]        dly;
        logic signed [ptq_pkg::PER_W-1:0] per;
        logic [ptq_pkg::STEP_W-1:0]       step;
        logic                             rep;
        r    = $urandom_range(0, 99);
        s    = ptq_pkg::SLOT_W'($urandom_range(0, 15));
        dly  = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 300);
        step = ($urandom_range(0, 6) == 0) ? ptq_pkg::STEP_W'($urandom_range(0, 65535))
                                           : ptq_pkg::STEP_W'($urandom_range(0, 200));
        rep  = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 19))
            0, 1, 2:  per = ONE_SHOT;
            3, 4, 5:  per = {1'b0, $urandom()};
            default:  per = ptq_pkg::PER_W'($urandom_range(0, 120));
        endcase
        if (r < 30) begin
            send_cmd(ptq_pkg::OP_ARM, s, dly, per, rep, step);
        end
        else if (r < 55) begin
            send_cmd(ptq_pkg::OP_ADVANCE, s, dly, per, rep, step);
        end
        else if (r < 75) begin
            send_cmd(ptq_pkg::OP_UPDATE, s, dly, per, rep, step);
        end
        else if (r < 87) begin
            send_cmd(ptq_pkg::OP_QUERY, s, dly, per, rep, step);
        end
        else if (r < 92) begin
            send_cmd(ptq_pkg::OP_PAUSE, s, dly, per, rep, step);
        end
        else if (r < 98) begin
            send_cmd(ptq_pkg::OP_START, s, dly, per, rep, step);
        end
        else begin
            send_cmd(($urandom_range(0, 1) != 0) ? OP_RSVD_7 : OP_RSVD_6,
                     s, dly, per, rep, step);
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        opcode     <= ptq_pkg::OP_ARM;
        slot       <= '0;
        delay      <= '0;
        period     <= '0;
        repeat_req <= 1'b0;
        time_step  <= '0;
        rand_sent    = 0;
        send_calm    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // negative interval with repeat set still makes a one-shot
        send_cmd(ptq_pkg::OP_ARM,    4'd0, 32'd0, ONE_SHOT, 1'b1, 16'd0);
        send_cmd(ptq_pkg::OP_QUERY,  4'd0, 32'd0, '0, 1'b0, 16'd0);
        send_cmd(ptq_pkg::OP_UPDATE, 4'd0, 32'd0, '0, 1'b0, 16'd0);
        // unarmed slot query
        send_cmd(ptq_pkg::OP_QUERY,  4'd0, 32'd0, '0, 1'b0, 16'd0);
        // largest delay and interval
        send_cmd(ptq_pkg::OP_ARM,   4'd15, 32'hFFFF_FFFF, 33'sh0_FFFF_FFFF, 1'b1, 16'hFFFF);
        send_cmd(ptq_pkg::OP_QUERY, 4'd15, 32'd0, '0, 1'b0, 16'd0);
        // pause twice, advance while paused, start twice
        send_cmd(ptq_pkg::OP_PAUSE,   4'd0, 32'd0, '0, 1'b0, 16'd0);
        send_cmd(ptq_pkg::OP_PAUSE,   4'd0, 32'd0, '0, 1'b0, 16'd0);
        send_cmd(ptq_pkg::OP_ADVANCE, 4'd0, 32'd0, '0, 1'b0, 16'hFFFF);
        send_cmd(ptq_pkg::OP_START,   4'd0, 32'd0, '0, 1'b0, 16'd0);
        send_cmd(ptq_pkg::OP_START,   4'd0, 32'd0, '0, 1'b0, 16'd0);
        send_cmd(ptq_pkg::OP_ADVANCE, 4'd0, 32'd0, '0, 1'b0, 16'hFFFF);
        // zero interval repeater, a tie on its deadline, and an earlier one-shot
        send_cmd(ptq_pkg::OP_ARM,     4'd5, 32'd10, 33'sd0,  1'b1, 16'd0);
        send_cmd(ptq_pkg::OP_ARM,     4'd2, 32'd10, 33'sd20, 1'b0, 16'd0);
        send_cmd(ptq_pkg::OP_ARM,     4'd9, 32'd4,  ONE_SHOT, 1'b0, 16'd0);
        send_cmd(ptq_pkg::OP_UPDATE,  4'd0, 32'd0, '0, 1'b0, 16'd0);
        send_cmd(ptq_pkg::OP_ADVANCE, 4'd0, 32'd0, '0, 1'b0, 16'd10);
        send_cmd(ptq_pkg::OP_UPDATE,  4'd0, 32'd0, '0, 1'b0, 16'd0);
        send_cmd(ptq_pkg::OP_UPDATE,  4'd0, 32'd0, '0, 1'b0, 16'd0);
        // overwrite the repeater as a one-shot
        send_cmd(ptq_pkg::OP_ARM,    4'd5, 32'd0, 33'sd7, 1'b0, 16'd0);
        send_cmd(ptq_pkg::OP_QUERY,  4'd5, 32'd0, '0, 1'b0, 16'd0);
        send_cmd(ptq_pkg::OP_UPDATE, 4'd0, 32'd0, '0, 1'b0, 16'd0);
        // reserved codes are acknowledged only
        send_cmd(OP_RSVD_6, 4'd0, 32'd0, '0, 1'b0, 16'd0);
        send_cmd(OP_RSVD_7, 4'hF, 32'hFFFF_FFFF, ONE_SHOT, 1'b1, 16'hFFFF);
        send_cmd(ptq_pkg::OP_ADVANCE, 4'd0, 32'd0, '0, 1'b0, 16'd0);

        // random phase
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 16 == 0)
                send_calm = ($urandom_range(0, 3) == 0);
            send_random();
            rand_sent++;
        end
        in_valid <= 1'b0;

        // let the checker take in the last transfer before draining
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("tb_pausable_timer_event_queue passed");
        else
            $display("tb_pausable_timer_event_queue failed");
        $finish;
    end

endmodule

// ===== pausable_timer_event_queue.f =====
hdl/ptq_pkg.sv
hdl/ptq_alu.sv
hdl/pausable_timer_event_queue.sv
sim/ptq_checker.sv
sim/tb_pausable_timer_event_queue.sv
